// File: hw/rtl/tpip_pkg.sv
package tpip_pkg;

    // default and port width of a vertex index
    localparam int INDEX_WIDTH = 32;
    localparam int PORT_WIDTH  = 32;

    // one queue entry holds up to two singles or one pair
    localparam int SLOTS      = 6;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int SINGLE_LEN = 3;
    localparam int PAIR_LEN   = 4;
    localparam int DOUBLE_LEN = 6;

    // entries between front and back
    localparam int QUEUE_DEPTH = 2;

endpackage

// File: hw/rtl/tpip_front.sv
module tpip_front #(
    parameter int W = tpip_pkg::INDEX_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [W-1:0]                          i_first,
    input  logic [W-1:0]                          i_second,
    input  logic [W-1:0]                          i_third,
    input  logic                                  i_final,
    input  logic                                  i_full,
    output logic                                  o_push,
    output logic [tpip_pkg::SLOTS-1:0][W-1:0]     o_slots,
    output logic [tpip_pkg::CNT_W-1:0]            o_cnt
);

    logic                r_pend_valid;
    logic                n_pend_valid;
    logic [2:0][W-1:0]   r_pend;
    logic [2:0][W-1:0]   tri_new;
    logic [2:0][W-1:0]   rot_pend;
    logic [2:0][W-1:0]   rot_new;
    logic                accept;
    logic                nondeg;
    logic                found;
    logic                merge;
    logic [W-1:0]        ea;
    logic [W-1:0]        eb;
    logic [W-1:0]        ec;
    logic [W-1:0]        ed;

    // rotate a single so that its first index is >= its second
    function automatic logic [2:0][W-1:0] rot3(input logic [2:0][W-1:0] t);
        logic [2:0][W-1:0] r;
        if (t[0] >= t[1]) begin
            r[0] = t[0]; r[1] = t[1]; r[2] = t[2];
        end else if (t[1] >= t[2]) begin
            r[0] = t[1]; r[1] = t[2]; r[2] = t[0];
        end else begin
            r[0] = t[2]; r[1] = t[0]; r[2] = t[1];
        end
        return r;
    endfunction

    assign tri_new[0] = i_first;
    assign tri_new[1] = i_second;
    assign tri_new[2] = i_third;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    assign rot_pend = rot3(r_pend);
    assign rot_new  = rot3(tri_new);

    // pending triangle must have three distinct corners to pair
    assign nondeg = (r_pend[0] != r_pend[1]) && (r_pend[1] != r_pend[2])
                 && (r_pend[2] != r_pend[0]);

    // search for a shared edge, pending edges in order, then new edges
    always_comb begin
        found = 1'b0;
        ea    = r_pend[0];
        eb    = r_pend[1];
        ec    = r_pend[2];
        ed    = tri_new[2];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (!found && tri_new[j] == r_pend[(i + 1) % 3]
                        && tri_new[(j + 1) % 3] == r_pend[i]) begin
                    found = 1'b1;
                    ea    = r_pend[i];
                    eb    = r_pend[(i + 1) % 3];
                    ec    = r_pend[(i + 2) % 3];
                    ed    = tri_new[(j + 2) % 3];
                end
            end
        end
    end

    assign merge = r_pend_valid && nondeg && found;

    // build the queue entry for this transaction
    always_comb begin
        o_slots      = '0;
        o_cnt        = '0;
        n_pend_valid = r_pend_valid;
        if (merge) begin
            if (ea < eb) begin
                o_slots[0] = ea; o_slots[1] = eb; o_slots[2] = ec; o_slots[3] = ed;
            end else begin
                o_slots[0] = eb; o_slots[1] = ea; o_slots[2] = ed; o_slots[3] = ec;
            end
            o_cnt        = tpip_pkg::CNT_W'(tpip_pkg::PAIR_LEN);
            n_pend_valid = 1'b0;
        end else if (r_pend_valid) begin
            o_slots[2:0] = rot_pend;
            if (i_final) begin
                o_slots[5:3] = rot_new;
                o_cnt        = tpip_pkg::CNT_W'(tpip_pkg::DOUBLE_LEN);
                n_pend_valid = 1'b0;
            end else begin
                o_cnt        = tpip_pkg::CNT_W'(tpip_pkg::SINGLE_LEN);
                n_pend_valid = 1'b1;
            end
        end else begin
            if (i_final) begin
                o_slots[2:0] = rot_new;
                o_cnt        = tpip_pkg::CNT_W'(tpip_pkg::SINGLE_LEN);
                n_pend_valid = 1'b0;
            end else begin
                n_pend_valid = 1'b1;
            end
        end
    end

    assign o_push = accept && (o_cnt != '0);

    // pending flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (accept) begin
            r_pend_valid <= n_pend_valid;
        end
    end

    // pending corners, loaded whenever a new triangle is kept
    always_ff @(posedge i_clk) begin
        if (accept && !merge && !i_final) begin
            r_pend <= tri_new;
        end
    end

    a_push_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_cnt == tpip_pkg::CNT_W'(tpip_pkg::SINGLE_LEN)
                 || o_cnt == tpip_pkg::CNT_W'(tpip_pkg::PAIR_LEN)
                 || o_cnt == tpip_pkg::CNT_W'(tpip_pkg::DOUBLE_LEN)))
        else $error("front pushed an entry of bad length");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_final) |=> !r_pend_valid)
        else $error("triangle left pending after final transaction");

endmodule

// File: hw/rtl/tpip_queue.sv
module tpip_queue #(
    parameter int W = tpip_pkg::INDEX_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  logic [tpip_pkg::SLOTS-1:0][W-1:0]     i_slots,
    input  logic [tpip_pkg::CNT_W-1:0]            i_cnt,
    output logic                                  o_full,
    input  logic                                  i_pop,
    output logic                                  o_valid,
    output logic [tpip_pkg::SLOTS-1:0][W-1:0]     o_slots,
    output logic [tpip_pkg::CNT_W-1:0]            o_cnt
);

    localparam int DEPTH = tpip_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [tpip_pkg::SLOTS-1:0][W-1:0]  r_slots [DEPTH];
    logic [tpip_pkg::CNT_W-1:0]         r_cnt   [DEPTH];
    logic [PTR_W-1:0]                   r_wr_ptr;
    logic [PTR_W-1:0]                   r_rd_ptr;
    logic [FILL_W-1:0]                  r_fill;
    logic [PTR_W-1:0]                   n_wr_ptr;
    logic [PTR_W-1:0]                   n_rd_ptr;

    assign o_full  = (r_fill == FILL_W'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_slots = r_slots[r_rd_ptr];
    assign o_cnt   = r_cnt[r_rd_ptr];

    // wrapping pointers
    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_slots;
            r_cnt[r_wr_ptr]   <= i_cnt;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(DEPTH))
        else $error("queue fill level beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

// File: hw/rtl/tpip_back.sv
module tpip_back #(
    parameter int W = tpip_pkg::INDEX_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_head_valid,
    input  logic [tpip_pkg::SLOTS-1:0][W-1:0]     i_head_slots,
    input  logic [tpip_pkg::CNT_W-1:0]            i_head_cnt,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [W-1:0]                          o_index,
    output logic                                  o_run_end
);

    logic [tpip_pkg::SLOT_W-1:0]  r_slot;
    logic                         r_valid;
    logic [W-1:0]                 r_index;
    logic                         r_run_end;
    logic                         load;
    logic                         last;

    // output register takes a new index when empty or being drained
    assign load = i_head_valid && (!r_valid || !i_stall);
    assign last = (tpip_pkg::CNT_W'(r_slot) == i_head_cnt - tpip_pkg::CNT_W'(1));
    assign o_pop = load && last;

    assign o_valid   = r_valid;
    assign o_index   = r_index;
    assign o_run_end = r_run_end;

    // slot counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_slot  <= last ? '0 : r_slot + tpip_pkg::SLOT_W'(1);
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_index   <= i_head_slots[r_slot];
            r_run_end <= last;
        end
    end

    a_slot_in_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (tpip_pkg::CNT_W'(r_slot) < i_head_cnt))
        else $error("slot counter beyond entry length");

    a_pop_resets_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_slot == '0))
        else $error("slot counter not cleared after entry finished");

endmodule

// File: hw/rtl/triangle_pair_index_packer.sv
// Packs a stream of triangles into singles (three indices, rotated so the first is >= the
// second) and shared-edge pairs (four indices); results leave one index per cycle while
// i_stall is low, with o_run_end on the last index caused by a transaction. An input
// transaction is accepted in the cycle it is offered as long as the two-entry queue between
// the classifier and the output serializer has room, so o_stall rises only when both
// entries are waiting. The output serializer sets the sustained rate: three indices per
// single, four per pair, six for a final transaction that flushes two singles, and none for
// a triangle held as pending. Entries pass through the queue and then the output register.
module triangle_pair_index_packer #(
    parameter int INDEX_WIDTH = tpip_pkg::INDEX_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [tpip_pkg::PORT_WIDTH-1:0]    i_first_index,
    input  logic [tpip_pkg::PORT_WIDTH-1:0]    i_second_index,
    input  logic [tpip_pkg::PORT_WIDTH-1:0]    i_third_index,
    input  logic                               i_final_triangle,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [tpip_pkg::PORT_WIDTH-1:0]    o_packed_index,
    output logic                               o_run_end
);

    logic                                             q_full;
    logic                                             q_push;
    logic [tpip_pkg::SLOTS-1:0][INDEX_WIDTH-1:0]      push_slots;
    logic [tpip_pkg::CNT_W-1:0]                       push_cnt;
    logic                                             q_pop;
    logic                                             head_valid;
    logic [tpip_pkg::SLOTS-1:0][INDEX_WIDTH-1:0]      head_slots;
    logic [tpip_pkg::CNT_W-1:0]                       head_cnt;
    logic [INDEX_WIDTH-1:0]                           out_index;

    // classify each transaction and build its queue entry
    tpip_front #(.W(INDEX_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_first  (i_first_index[INDEX_WIDTH-1:0]),
        .i_second (i_second_index[INDEX_WIDTH-1:0]),
        .i_third  (i_third_index[INDEX_WIDTH-1:0]),
        .i_final  (i_final_triangle),
        .i_full   (q_full),
        .o_push   (q_push),
        .o_slots  (push_slots),
        .o_cnt    (push_cnt)
    );

    // decoupling queue
    tpip_queue #(.W(INDEX_WIDTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_slots (push_slots),
        .i_cnt   (push_cnt),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (head_valid),
        .o_slots (head_slots),
        .o_cnt   (head_cnt)
    );

    // serialize entries onto the output channel
    tpip_back #(.W(INDEX_WIDTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_slots (head_slots),
        .i_head_cnt   (head_cnt),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_index      (out_index),
        .o_run_end    (o_run_end)
    );

    assign o_packed_index = tpip_pkg::PORT_WIDTH'(out_index);

endmodule

// File: verif/triangle_pair_index_packer_test.sv
module triangle_pair_index_packer_test;

    localparam int PW = tpip_pkg::PORT_WIDTH;
    localparam int IW = tpip_pkg::INDEX_WIDTH;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [PW-1:0] ALL_ONES = '1;

    typedef logic [IW-1:0] t_idx;
    typedef logic [2:0][IW-1:0] t_corners;
    typedef logic [2:0][PW-1:0] t_port_corners;

    typedef struct packed {
        logic [PW-1:0] index;
        logic          run_end;
    } t_packed_word;

    // value pools for random triangles
    typedef enum {
        POOL_TINY,
        POOL_FULL,
        POOL_EXTREMES,
        POOL_MIXED
    } t_index_pool;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    logic [PW-1:0] i_first_index = '0;
    logic [PW-1:0] i_second_index = '0;
    logic [PW-1:0] i_third_index = '0;
    logic          i_final_triangle = 1'b0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    logic [PW-1:0] o_packed_index;
    logic          o_run_end;

    // packer state as the predictor sees it
    bit           held_valid = 1'b0;
    t_corners     held_corners;
    t_packed_word expected_words[$];

    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  result_hold = 0;
    bit  steady_flow = 1'b0;

    triangle_pair_index_packer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_first_index    (i_first_index),
        .i_second_index   (i_second_index),
        .i_third_index    (i_third_index),
        .i_final_triangle (i_final_triangle),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_packed_index   (o_packed_index),
        .o_run_end        (o_run_end)
    );

    always #5 i_clk = ~i_clk;

    function automatic int draw_wait();
        return steady_flow ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic void push_word(t_idx v, bit run_end);
        t_packed_word w;
        w.index = PW'(v);
        w.run_end = run_end;
        expected_words.insert(expected_words.size(), w);
    endfunction

    // single: rotated so that the first index is >= the second
    function automatic void push_single(t_corners t, bit ends_run);
        if (t[0] >= t[1]) begin
            push_word(t[0], 1'b0); push_word(t[1], 1'b0); push_word(t[2], ends_run);
        end else if (t[1] >= t[2]) begin
            push_word(t[1], 1'b0); push_word(t[2], 1'b0); push_word(t[0], ends_run);
        end else begin
            push_word(t[2], 1'b0); push_word(t[0], 1'b0); push_word(t[1], ends_run);
        end
    endfunction

    // pair: first pending edge whose reverse appears in the new triangle
    function automatic bit push_pair(t_corners p, t_corners n);
        t_idx a, b, c, d;
        if (p[0] == p[1] || p[1] == p[2] || p[2] == p[0])
            return 1'b0;
        for (int i = 0; i < 3; i++) begin
            a = p[i];
            b = p[(i + 1) % 3];
            c = p[(i + 2) % 3];
            for (int j = 0; j < 3; j++) begin
                if (n[j] == b && n[(j + 1) % 3] == a) begin
                    d = n[(j + 2) % 3];
                    if (a < b) begin
                        push_word(a, 1'b0); push_word(b, 1'b0);
                        push_word(c, 1'b0); push_word(d, 1'b1);
                    end else begin
                        push_word(b, 1'b0); push_word(a, 1'b0);
                        push_word(d, 1'b0); push_word(c, 1'b1);
                    end
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // expected indices for one accepted triangle
    function automatic void pack_triangle(logic [PW-1:0] a, logic [PW-1:0] b,
                                          logic [PW-1:0] c, logic closing);
        t_corners t;
        t[0] = a[IW-1:0];
        t[1] = b[IW-1:0];
        t[2] = c[IW-1:0];
        if (held_valid) begin
            if (push_pair(held_corners, t)) begin
                held_valid = 1'b0;
                return;
            end
            push_single(held_corners, !closing);
        end
        if (closing) begin
            push_single(t, 1'b1);
            held_valid = 1'b0;
        end else begin
            held_corners = t;
            held_valid = 1'b1;
        end
    endfunction

    // one input transaction, entered and left at a rising edge
    task automatic send_triangle(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                 input logic [PW-1:0] c, input logic closing);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_first_index <= a;
        i_second_index <= b;
        i_third_index <= c;
        i_final_triangle <= closing;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        pack_triangle(a, b, c, closing);
    endtask

    function automatic logic [PW-1:0] random_index(t_index_pool pool);
        case (pool)
            POOL_TINY:     return PW'($urandom_range(0, 7));
            POOL_FULL:     return PW'($urandom);
            POOL_EXTREMES: return $urandom_range(0, 1) ? PW'($urandom_range(0, 3))
                                                       : ALL_ONES - PW'($urandom_range(0, 3));
            default:       return $urandom_range(0, 1) ? PW'($urandom_range(0, 7))
                                                       : PW'($urandom);
        endcase
    endfunction

    // strips of edge-sharing triangles, with unrelated triangles mixed in
    task automatic run_strips(input int count);
        t_port_corners cur, nxt;
        t_index_pool   pool;
        int            sent, len, e, j;
        logic          closing;
        sent = 0;
        while (sent < count) begin
            pool = t_index_pool'($urandom_range(0, 3));
            len = $urandom_range(1, 10);
            for (int k = 0; k < 3; k++) cur[k] = random_index(pool);
            for (int k = 0; k < len && sent < count; k++) begin
                if (k > 0) begin
                    if ($urandom_range(0, 9) < 7) begin
                        e = $urandom_range(0, 2);
                        j = $urandom_range(0, 2);
                        nxt[j] = cur[(e + 1) % 3];
                        nxt[(j + 1) % 3] = cur[e];
                        nxt[(j + 2) % 3] = random_index(pool);
                        cur = nxt;
                    end else begin
                        for (int m = 0; m < 3; m++) cur[m] = random_index(pool);
                    end
                end
                closing = (k == len - 1) ? ($urandom_range(0, 1) == 1)
                                         : ($urandom_range(0, 15) == 0);
                send_triangle(cur[0], cur[1], cur[2], closing);
                sent++;
            end
        end
    endtask

    // lone triangles: rotation rule, extremes, degenerate ones
    task automatic test_directed_singles();
        send_triangle('0, '0, '0, 1'b1);
        send_triangle(ALL_ONES, ALL_ONES, ALL_ONES, 1'b1);
        send_triangle(5, 3, 1, 1'b1);
        send_triangle(1, 7, 2, 1'b1);
        send_triangle(1, 2, ALL_ONES, 1'b1);
    endtask

    // merges on each edge, merges with and without the last triangle, refused merges
    task automatic test_directed_pairs();
        send_triangle(1, 2, 3, 1'b0);
        send_triangle(2, 1, 4, 1'b1);
        send_triangle(ALL_ONES, 0, 5, 1'b0);
        send_triangle(9, 0, ALL_ONES, 1'b0);
        send_triangle(10, 20, 30, 1'b0);
        send_triangle(40, 30, 20, 1'b0);
        send_triangle(7, 8, 9, 1'b0);
        send_triangle(11, 7, 9, 1'b1);
        // no merge on the last triangle flushes two singles
        send_triangle(1, 2, 3, 1'b0);
        send_triangle(4, 5, 6, 1'b1);
        // degenerate pending triangle is never merged
        send_triangle(5, 5, 6, 1'b0);
        send_triangle(5, 5, 7, 1'b1);
        // shared edge in the same direction does not merge
        send_triangle(1, 2, 3, 1'b0);
        send_triangle(1, 2, 4, 1'b0);
        send_triangle(2, 1, 8, 1'b1);
    endtask

    task automatic test_random_strips();
        run_strips(140);
    endtask

    // both sides run without idle cycles
    task automatic test_back_to_back();
        steady_flow = 1'b1;
        run_strips(40);
        steady_flow = 1'b0;
    endtask

    // output side: random stall per transaction and result check
    always @(posedge i_clk) begin
        t_packed_word want;
        int hold;
        if (i_rst_n) begin
            if (o_valid === 1'b1 && !i_stall) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: index %h run_end %b",
                                 o_packed_index, o_run_end);
                end else begin
                    want = expected_words.pop_front();
                    if (o_packed_index !== want.index || o_run_end !== want.run_end) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected index %h run_end %b, got %h %b",
                                     want.index, want.run_end, o_packed_index, o_run_end);
                    end
                end
                hold = draw_wait();
                result_hold <= hold;
                i_stall <= (hold != 0);
            end else if (result_hold > 1) begin
                result_hold <= result_hold - 1;
            end else begin
                result_hold <= 0;
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("triangle_pair_index_packer regression: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_singles();
        test_directed_pairs();
        test_random_strips();
        test_back_to_back();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", expected_words.size());
        end
        if (mismatches == 0)
            $display("triangle_pair_index_packer regression: pass");
        else
            $display("triangle_pair_index_packer regression: fail");
        $finish;
    end

endmodule
